FILE: hdl/bics_pkg.sv
// Shared constants, codes and types of the byte interval coverage set unit.
package bics_pkg;

  localparam int unsigned MAX_INTERVALS = 32;
  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned POS_W = 48;
  localparam int unsigned START_W = 47;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_COVERED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COVERS  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GAPS    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SHRINK  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_EXTEND  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_EXTEND = 2'd2;

  typedef enum logic [1:0] {
    SRC_RIGHT,
    SRC_LEFT,
    SRC_NEW
  } cell_src_e;

  typedef struct packed {
    logic      en;
    cell_src_e src;
  } cell_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] beg;
    logic [POS_W-1:0] fin;
  } interval_t;

endpackage

FILE: hdl/byte_interval_coverage_set_unit.sv
// Top level: a ring of interval cells scanned through a head unit, plus the sequencer.
//
//  channel | direction | handshake               | words
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | action, range_start, range_length
//  out     | output    | out_valid_o/out_stall_i | result_start, result_length,
//          |           |                         | fully_covered, status, last
//
// Queries pass the whole ring once under the head cell, then the response state; gaps
// pass a final state for the tail gap first. Insert takes the edit state after the pass,
// writing once, or once per absorbed interval when it merges, then the response state.
// Shrink and extend take the head state, then the response state; unused actions go straight
// to it. One word is worked on at a time. Reset clears the interval count; cell contents are
// never cleared. A stalled output holds the ring whenever a further gap must be reported.
module byte_interval_coverage_set_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bics_pkg::ACT_W-1:0]     action_i,
  input  logic [bics_pkg::START_W-1:0]   range_start_i,
  input  logic [bics_pkg::LEN_W-1:0]     range_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bics_pkg::POS_W-1:0]     result_start_o,
  output logic [bics_pkg::LEN_W-1:0]     result_length_o,
  output logic                           fully_covered_o,
  output logic [bics_pkg::STAT_W-1:0]    status_o,
  output logic                           last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EDIT = 3'd2;
  localparam logic [2:0] ST_HEAD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_RESP = 3'd5;

  localparam int unsigned N = bics_pkg::MAX_INTERVALS;
  localparam int unsigned CW = bics_pkg::CNT_W;
  localparam int unsigned PW = bics_pkg::POS_W;
  localparam int unsigned LW = bics_pkg::LEN_W;

  logic [2:0] state_q, state_d;
  logic [bics_pkg::ACT_W-1:0] act_q, act_d;
  logic [bics_pkg::START_W-1:0] s_q, s_d;
  logic [LW-1:0] len_q, len_d;
  logic [PW-1:0] e_q, e_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic fi_q, fi_d, stop_q, stop_d, found_q, found_d, full_q, full_d;
  logic pend_v_q, pend_v_d;
  logic [PW-1:0] ms_q, ms_d, me_q, me_d, cur_q, cur_d, pend_s_q, pend_s_d;
  logic [LW-1:0] total_q, total_d, pend_l_q, pend_l_d;
  logic [bics_pkg::STAT_W-1:0] status_q, status_d;

  logic out_valid_q, out_valid_d;
  logic [PW-1:0] res_start_q;
  logic [LW-1:0] res_len_q;
  logic res_full_q, res_last_q;
  logic [bics_pkg::STAT_W-1:0] res_status_q;

  logic load_out, ld_full, ld_last;
  logic [PW-1:0] ld_start;
  logic [LW-1:0] ld_len;
  logic [bics_pkg::STAT_W-1:0] ld_status;

  logic rot_all, ins_en, mrg_wr, mrg_sh, head_wr;
  bics_pkg::interval_t wdata;
  bics_pkg::interval_t cells_q [N];
  bics_pkg::cell_ctrl_t ctrl [N];

  logic in_accept, out_free, len_nz, ent_valid, g_hit, g_new, need_out, scan_adv, tail;
  logic [PW-1:0] hb, hf, s48, e_in, lo, hi, len48;
  logic [LW-1:0] ov;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign hb = cells_q[0].beg;
  assign hf = cells_q[0].fin;
  assign s48 = {1'b0, s_q};
  assign len48 = {{(PW-LW){1'b0}}, len_q};
  assign e_in = {1'b0, range_start_i} + {{(PW-LW){1'b0}}, range_length_i};
  assign len_nz = (len_q != '0);
  assign ent_valid = (k_q < cnt_q);

  assign lo = (hb > s48) ? hb : s48;
  assign hi = (hf < e_q) ? hf : e_q;
  assign ov = (lo < hi) ? (hi[LW-1:0] - lo[LW-1:0]) : '0;

  assign g_hit = ent_valid && len_nz && !stop_q && (hf > s48) && (hb < e_q);
  assign g_new = g_hit && (hb > cur_q);
  assign need_out = (act_q == bics_pkg::ACT_GAPS) && g_new && pend_v_q;
  assign scan_adv = (state_q == ST_SCAN) && !(need_out && !out_free);
  assign tail = len_nz && (cur_q < e_q);

  always_comb begin
    state_d = state_q;
    act_d = act_q;
    s_d = s_q;
    len_d = len_q;
    e_d = e_q;
    k_d = k_q;
    cnt_d = cnt_q;
    i_d = i_q;
    j_d = j_q;
    fi_d = fi_q;
    stop_d = stop_q;
    found_d = found_q;
    full_d = full_q;
    pend_v_d = pend_v_q;
    ms_d = ms_q;
    me_d = me_q;
    cur_d = cur_q;
    pend_s_d = pend_s_q;
    pend_l_d = pend_l_q;
    total_d = total_q;
    status_d = status_q;
    load_out = 1'b0;
    ld_start = '0;
    ld_len = '0;
    ld_full = 1'b0;
    ld_status = bics_pkg::STAT_OK;
    ld_last = 1'b0;
    rot_all = 1'b0;
    ins_en = 1'b0;
    mrg_wr = 1'b0;
    mrg_sh = 1'b0;
    head_wr = 1'b0;
    wdata = '{beg: ms_q, fin: me_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          act_d = action_i;
          s_d = range_start_i;
          len_d = range_length_i;
          e_d = e_in;
          k_d = '0;
          i_d = '0;
          j_d = '0;
          fi_d = 1'b0;
          stop_d = 1'b0;
          found_d = 1'b0;
          full_d = (range_length_i == '0);
          pend_v_d = 1'b0;
          ms_d = {1'b0, range_start_i};
          me_d = e_in;
          cur_d = {1'b0, range_start_i};
          total_d = '0;
          status_d = bics_pkg::STAT_OK;
          unique case (action_i)
            bics_pkg::ACT_INSERT, bics_pkg::ACT_COVERED,
            bics_pkg::ACT_COVERS, bics_pkg::ACT_GAPS: state_d = ST_SCAN;
            bics_pkg::ACT_SHRINK, bics_pkg::ACT_EXTEND: state_d = ST_HEAD;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_adv) begin
          rot_all = 1'b1;
          k_d = k_q + CW'(1);
          if (ent_valid) begin
            unique case (act_q)
              bics_pkg::ACT_INSERT: begin
                if (!fi_q && (hf < s48)) begin
                  i_d = k_q + CW'(1);
                  j_d = k_q + CW'(1);
                end else begin
                  fi_d = 1'b1;
                  if (!stop_q && (hb <= me_q)) begin
                    if (hb < ms_q) ms_d = hb;
                    if (hf > me_q) me_d = hf;
                    j_d = k_q + CW'(1);
                  end else begin
                    stop_d = 1'b1;
                  end
                end
              end
              bics_pkg::ACT_COVERED: begin
                if (len_nz) total_d = total_q + ov;
              end
              bics_pkg::ACT_COVERS: begin
                if (len_nz && !found_q && (hf > s48)) begin
                  found_d = 1'b1;
                  full_d = (hb <= s48) && (hf >= e_q);
                end
              end
              bics_pkg::ACT_GAPS: begin
                if (g_hit) begin
                  if (g_new) begin
                    if (pend_v_q) begin
                      load_out = 1'b1;
                      ld_start = pend_s_q;
                      ld_len = pend_l_q;
                    end
                    pend_s_d = cur_q;
                    pend_l_d = hb[LW-1:0] - cur_q[LW-1:0];
                    pend_v_d = 1'b1;
                  end
                  if (hf > cur_q) cur_d = hf;
                end else if (len_nz && !stop_q && (hf > s48)) begin
                  stop_d = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          if (k_q == CW'(N - 1)) begin
            unique case (act_q)
              bics_pkg::ACT_INSERT: state_d = ST_EDIT;
              bics_pkg::ACT_GAPS:   state_d = ST_FIN;
              default:              state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_EDIT: begin
        if (!len_nz) begin
          state_d = ST_RESP;
        end else if (i_q == j_q) begin
          if (cnt_q >= CW'(N)) begin
            status_d = bics_pkg::STAT_FULL;
          end else begin
            ins_en = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
          state_d = ST_RESP;
        end else begin
          mrg_wr = 1'b1;
          if ((j_q - i_q) > CW'(1)) begin
            mrg_sh = 1'b1;
            j_d = j_q - CW'(1);
            cnt_d = cnt_q - CW'(1);
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_HEAD: begin
        if (act_q == bics_pkg::ACT_SHRINK) begin
          if (len_nz && (cnt_q != '0)) begin
            if (len48 >= (hf - hb)) begin
              rot_all = 1'b1;
              cnt_d = cnt_q - CW'(1);
            end else begin
              head_wr = 1'b1;
              wdata = '{beg: hb + len48, fin: hf};
            end
          end
        end else if (len_nz) begin
          if ((cnt_q == '0) || (hb < len48)) begin
            status_d = bics_pkg::STAT_BAD_EXTEND;
          end else begin
            head_wr = 1'b1;
            wdata = '{beg: hb - len48, fin: hf};
          end
        end
        state_d = ST_RESP;
      end
      ST_FIN: begin
        if (!tail) begin
          state_d = ST_RESP;
        end else if (pend_v_q) begin
          if (out_free) begin
            load_out = 1'b1;
            ld_start = pend_s_q;
            ld_len = pend_l_q;
            pend_s_d = cur_q;
            pend_l_d = e_q[LW-1:0] - cur_q[LW-1:0];
            state_d = ST_RESP;
          end
        end else begin
          pend_s_d = cur_q;
          pend_l_d = e_q[LW-1:0] - cur_q[LW-1:0];
          pend_v_d = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_last = 1'b1;
          ld_status = status_q;
          if ((act_q == bics_pkg::ACT_GAPS) && pend_v_q) begin
            ld_start = pend_s_q;
            ld_len = pend_l_q;
          end
          if (act_q == bics_pkg::ACT_COVERED) ld_len = total_q;
          if (act_q == bics_pkg::ACT_COVERS) ld_full = full_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      ctrl[k] = '{en: 1'b0, src: bics_pkg::SRC_RIGHT};
      if (rot_all) begin
        ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_RIGHT};
      end else if (ins_en) begin
        if (CW'(k) == i_q) ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_NEW};
        else if (CW'(k) > i_q) ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_LEFT};
      end else if (mrg_wr) begin
        if (CW'(k) == i_q) ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_NEW};
        else if ((CW'(k) > i_q) && mrg_sh) ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_RIGHT};
      end else if (head_wr && (k == 0)) begin
        ctrl[k] = '{en: 1'b1, src: bics_pkg::SRC_NEW};
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned RN = (g + 1) % N;
    localparam int unsigned LN = (g + N - 1) % N;
    bics_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .left_i  (cells_q[LN]),
      .right_i (cells_q[RN]),
      .new_i   (wdata),
      .q_o     (cells_q[g])
    );
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    s_q <= s_d;
    len_q <= len_d;
    e_q <= e_d;
    k_q <= k_d;
    i_q <= i_d;
    j_q <= j_d;
    fi_q <= fi_d;
    stop_q <= stop_d;
    found_q <= found_d;
    full_q <= full_d;
    ms_q <= ms_d;
    me_q <= me_d;
    cur_q <= cur_d;
    pend_s_q <= pend_s_d;
    pend_l_q <= pend_l_d;
    total_q <= total_d;
    status_q <= status_d;
    if (load_out) begin
      res_start_q <= ld_start;
      res_len_q <= ld_len;
      res_full_q <= ld_full;
      res_status_q <= ld_status;
      res_last_q <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_start_o = res_start_q;
  assign result_length_o = res_len_q;
  assign fully_covered_o = res_full_q;
  assign status_o = res_status_q;
  assign last_o = res_last_q;

endmodule

FILE: hdl/bics_cell.sv
// One table cell: holds one interval and loads from a neighbor or the write bus.
module bics_cell (
  input  logic                   clk_i,
  input  bics_pkg::cell_ctrl_t   ctrl_i,
  input  bics_pkg::interval_t    left_i,
  input  bics_pkg::interval_t    right_i,
  input  bics_pkg::interval_t    new_i,
  output bics_pkg::interval_t    q_o
);

  bics_pkg::interval_t q_q, q_d;

  always_comb begin
    q_d = q_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.src)
        bics_pkg::SRC_RIGHT: q_d = right_i;
        bics_pkg::SRC_LEFT:  q_d = left_i;
        bics_pkg::SRC_NEW:   q_d = new_i;
        default:             q_d = q_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

FILE: hdl/bics_checker.sv
// Port-level checker for the byte interval coverage set unit and its bind.
module bics_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [bics_pkg::POS_W-1:0]     result_start_o,
  input logic [bics_pkg::LEN_W-1:0]     result_length_o,
  input logic                           fully_covered_o,
  input logic [bics_pkg::STAT_W-1:0]    status_o,
  input logic                           last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_start_o) &&
    $stable(result_length_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= bics_pkg::STAT_BAD_EXTEND)
    else $error("unknown status code");

  a_mid_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == bics_pkg::STAT_OK && !fully_covered_o &&
    result_length_o != '0)
    else $error("non-final word is not a proper gap");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

endmodule

bind byte_interval_coverage_set_unit bics_checker u_bics_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_start_o  (result_start_o),
  .result_length_o (result_length_o),
  .fully_covered_o (fully_covered_o),
  .status_o        (status_o),
  .last_o          (last_o)
);
